// ===== rtl/pra_pkg.sv =====
// Shared types and constants for the reference-counted page allocator.
package pra_pkg;

   localparam int ADDR_W   = 27;
   localparam int COUNT_W  = 8;
   localparam int FREE_W   = 16;
   localparam int CFG_W    = 15;
   localparam int CPU_IN_W = 3;
   localparam int VALUE_W  = 8;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef enum logic [2:0] {
      KIND_ALLOC = 3'd0,
      KIND_FREE  = 3'd1,
      KIND_ADD   = 3'd2,
      KIND_SET   = 3'd3,
      KIND_CHECK = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_OOM      = 2'd1,
      STATUS_BAD_ADDR = 2'd2,
      STATUS_LIMIT    = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ALLOC,
      ST_COUNT
   } state_type;

   typedef struct packed {
      logic pop;
      logic push;
   } list_cmd_type;

endpackage

// ===== rtl/pra_ram.sv =====
// Simple dual-port synchronous RAM with a registered read port.
module pra_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/pra_heads.sv =====
// Per-CPU free list heads, round-robin source selection and the free page total.
module pra_heads #(
   parameter int NUM_PAGES = 32768,
   parameter int NUM_CPUS  = 8,
   localparam int HEAD_W   = $clog2(NUM_PAGES + 1),
   localparam int CPU_W    = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [CPU_W-1:0]           cpu_idx,
   input  logic [CPU_W-1:0]           pop_idx,
   input  pra_pkg::list_cmd_type      cmd,
   input  logic [HEAD_W-1:0]          pop_next,
   input  logic [HEAD_W-1:0]          push_page,
   output logic                       sel_found,
   output logic [CPU_W-1:0]           sel_idx,
   output logic [HEAD_W-1:0]          sel_head,
   output logic [HEAD_W-1:0]          own_head,
   output logic [pra_pkg::FREE_W-1:0] free_after
);

   localparam logic [HEAD_W-1:0] EMPTY = HEAD_W'(NUM_PAGES);

   logic [HEAD_W-1:0]          heads_ff [NUM_CPUS];
   logic [HEAD_W-1:0]          heads_in [NUM_CPUS];
   logic [pra_pkg::FREE_W-1:0] total_ff;
   logic [pra_pkg::FREE_W-1:0] total_in;
   logic [NUM_CPUS-1:0]        nonempty;

   for (genvar i = 0; i < NUM_CPUS; i++) begin : g_lane
      assign nonempty[i] = heads_ff[i] < EMPTY;
   end

   // Rotating priority: the requester's own list first, then the following CPUs.
   always_comb begin
      logic [CPU_W:0]   sum;
      logic [CPU_W-1:0] idx;
      sel_found = 1'b0;
      sel_idx   = cpu_idx;
      for (int k = 0; k < NUM_CPUS; k++) begin
         sum = {1'b0, cpu_idx} + (CPU_W + 1)'(k);
         if (int'(sum) >= NUM_CPUS) begin
            sum = sum - (CPU_W + 1)'(NUM_CPUS);
         end
         idx = sum[CPU_W-1:0];
         if (!sel_found && nonempty[idx]) begin
            sel_found = 1'b1;
            sel_idx   = idx;
         end
      end
   end

   assign sel_head = heads_ff[sel_idx];
   assign own_head = heads_ff[cpu_idx];

   always_comb begin
      for (int i = 0; i < NUM_CPUS; i++) begin
         heads_in[i] = heads_ff[i];
      end
      total_in = total_ff;
      if (cmd.pop) begin
         heads_in[pop_idx] = pop_next;
         if (total_ff != '0) begin
            total_in = total_ff - 1'b1;
         end
      end else if (cmd.push) begin
         heads_in[cpu_idx] = push_page;
         if (total_ff != '1) begin
            total_in = total_ff + 1'b1;
         end
      end
   end

   assign free_after = total_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CPUS; i++) begin
            heads_ff[i] <= EMPTY;
         end
         total_ff <= '0;
      end else begin
         heads_ff <= heads_in;
         total_ff <= total_in;
      end
   end

endmodule

// ===== rtl/refcounted_page_allocator_core.sv =====
// Top level of the reference-counted per-CPU page allocator.
//
// After reset the block zeroes the reference count memory, one entry per cycle,
// and holds busy high meanwhile; configuration writes are taken at any time.
// A request is taken when start is high and busy is low. Requests that fail
// their address check, an alloc with every list empty and unknown kinds finish
// in the accept cycle; all other requests finish in the ST_ALLOC or ST_COUNT
// state that follows, which uses the registered read of the count or link
// memory and completes the write-back. Each result is shown on the rsp_ ports for one
// cycle with rsp_strobe, starting the cycle after the request completes, and
// must be taken then since the receiver cannot stall. The next request may be
// issued in the same cycle that a result is shown.
module refcounted_page_allocator_core #(
   parameter int NUM_PAGES  = 32768,
   parameter int NUM_CPUS   = 8,
   parameter int PAGE_BYTES = 4096
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [2:0]                   req_kind,
   input  logic [pra_pkg::CPU_IN_W-1:0] req_cpu,
   input  logic [pra_pkg::ADDR_W-1:0]   req_address,
   input  logic [pra_pkg::VALUE_W-1:0]  req_value,
   output logic                         rsp_strobe,
   output logic [1:0]                   rsp_status,
   output logic [pra_pkg::ADDR_W-1:0]   rsp_page_address,
   output logic                         rsp_matches_res,
   output logic [pra_pkg::FREE_W-1:0]   rsp_free_bytes_pages,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [pra_pkg::CFG_W-1:0]    csr_wdata
);

   localparam int PAGE_W     = $clog2(NUM_PAGES);
   localparam int HEAD_W     = $clog2(NUM_PAGES + 1);
   localparam int CPU_W      = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
   localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
   localparam int ADDR_W     = pra_pkg::ADDR_W;
   localparam int COUNT_W    = pra_pkg::COUNT_W;

   function automatic logic [CPU_W-1:0] cpu_wrap(input logic [pra_pkg::CPU_IN_W-1:0] c);
      logic [pra_pkg::CPU_IN_W:0] r;
      r = {1'b0, c};
      for (int i = 0; i < 8; i++) begin
         if (int'(r) >= NUM_CPUS) begin
            r = r - (pra_pkg::CPU_IN_W + 1)'(NUM_CPUS);
         end
      end
      return CPU_W'(r);
   endfunction

   pra_pkg::state_type  state_ff, state_in;
   logic [PAGE_W-1:0]   clear_ff, clear_in;
   logic [pra_pkg::CFG_W-1:0] cfg_ff, cfg_in;

   pra_pkg::kind_type   kind_ff, kind_in;
   logic [CPU_W-1:0]    cpu_ff, cpu_in;
   logic [PAGE_W-1:0]   page_ff, page_in;
   logic [pra_pkg::VALUE_W-1:0] value_ff, value_in;
   logic [CPU_W-1:0]    pop_ff, pop_in;
   logic [PAGE_W-1:0]   alloc_ff, alloc_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   pra_pkg::status_type        rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0]          rsp_addr_ff, rsp_addr_in;
   logic                       rsp_match_ff, rsp_match_in;
   logic [pra_pkg::FREE_W-1:0] rsp_free_ff, rsp_free_in;

   logic               cnt_we;
   logic [PAGE_W-1:0]  cnt_waddr, cnt_raddr;
   logic [COUNT_W-1:0] cnt_wdata, cnt_rdata;
   logic               lnk_we;
   logic [PAGE_W-1:0]  lnk_waddr, lnk_raddr;
   logic [HEAD_W-1:0]  lnk_wdata, lnk_rdata;

   pra_pkg::list_cmd_type      cmd;
   logic [CPU_W-1:0]           heads_cpu;
   logic                       sel_found;
   logic [CPU_W-1:0]           sel_idx;
   logic [HEAD_W-1:0]          sel_head;
   logic [HEAD_W-1:0]          own_head;
   logic [pra_pkg::FREE_W-1:0] free_after;

   pra_pkg::kind_type  req_kind_t;
   logic [CPU_W-1:0]   req_cpu_w;
   logic [ADDR_W-1:0]  page_full;
   logic [PAGE_W-1:0]  req_page;
   logic               in_range;
   logic               aligned;
   logic [ADDR_W-1:0]  alloc_wide;

   assign req_kind_t = pra_pkg::kind_type'(req_kind);
   assign req_cpu_w  = cpu_wrap(req_cpu);
   assign page_full  = ADDR_W'(req_address >> PAGE_SHIFT);
   assign req_page   = page_full[PAGE_W-1:0];
   assign in_range   = page_full < ADDR_W'(NUM_PAGES);
   assign aligned    = req_address[PAGE_SHIFT-1:0] == '0;
   assign alloc_wide = ADDR_W'(alloc_ff);
   assign heads_cpu  = (state_ff == pra_pkg::ST_IDLE) ? req_cpu_w : cpu_ff;

   pra_ram #(.WIDTH(COUNT_W), .DEPTH(NUM_PAGES)) u_counts (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (cnt_waddr),
      .wr_data (cnt_wdata),
      .rd_addr (cnt_raddr),
      .rd_data (cnt_rdata)
   );

   pra_ram #(.WIDTH(HEAD_W), .DEPTH(NUM_PAGES)) u_links (
      .clock   (clock),
      .wr_en   (lnk_we),
      .wr_addr (lnk_waddr),
      .wr_data (lnk_wdata),
      .rd_addr (lnk_raddr),
      .rd_data (lnk_rdata)
   );

   pra_heads #(.NUM_PAGES(NUM_PAGES), .NUM_CPUS(NUM_CPUS)) u_heads (
      .clock      (clock),
      .reset      (reset),
      .cpu_idx    (heads_cpu),
      .pop_idx    (pop_ff),
      .cmd        (cmd),
      .pop_next   (lnk_rdata),
      .push_page  (HEAD_W'(page_ff)),
      .sel_found  (sel_found),
      .sel_idx    (sel_idx),
      .sel_head   (sel_head),
      .own_head   (own_head),
      .free_after (free_after)
   );

   assign cfg_in = csr_valid ? csr_wdata : cfg_ff;

   always_comb begin
      state_in      = state_ff;
      clear_in      = clear_ff;
      kind_in       = kind_ff;
      cpu_in        = cpu_ff;
      page_in       = page_ff;
      value_in      = value_ff;
      pop_in        = pop_ff;
      alloc_in      = alloc_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = pra_pkg::STATUS_OK;
      rsp_addr_in   = '0;
      rsp_match_in  = 1'b0;
      rsp_free_in   = free_after;
      cnt_we        = 1'b0;
      cnt_waddr     = page_ff;
      cnt_wdata     = '0;
      cnt_raddr     = req_page;
      lnk_we        = 1'b0;
      lnk_waddr     = page_ff;
      lnk_wdata     = own_head;
      lnk_raddr     = sel_head[PAGE_W-1:0];
      cmd           = '0;

      case (state_ff)
         pra_pkg::ST_CLEAR: begin
            cnt_we    = 1'b1;
            cnt_waddr = clear_ff;
            if (clear_ff == PAGE_W'(NUM_PAGES - 1)) begin
               state_in = pra_pkg::ST_IDLE;
            end else begin
               clear_in = clear_ff + 1'b1;
            end
         end
         pra_pkg::ST_IDLE: begin
            if (start) begin
               kind_in  = req_kind_t;
               cpu_in   = req_cpu_w;
               page_in  = req_page;
               value_in = req_value;
               if (req_kind_t == pra_pkg::KIND_ALLOC) begin
                  if (sel_found) begin
                     // Claim the head page now; its link comes back next cycle.
                     cnt_we    = 1'b1;
                     cnt_waddr = sel_head[PAGE_W-1:0];
                     cnt_wdata = COUNT_W'(1);
                     pop_in    = sel_idx;
                     alloc_in  = sel_head[PAGE_W-1:0];
                     state_in  = pra_pkg::ST_ALLOC;
                  end else begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = pra_pkg::STATUS_OOM;
                  end
               end else if (req_kind_t == pra_pkg::KIND_FREE) begin
                  if (!aligned || !in_range || page_full < ADDR_W'(cfg_ff)) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = pra_pkg::STATUS_BAD_ADDR;
                  end else begin
                     state_in = pra_pkg::ST_COUNT;
                  end
               end else if (req_kind_t inside {pra_pkg::KIND_ADD, pra_pkg::KIND_SET,
                                               pra_pkg::KIND_CHECK}) begin
                  if (!in_range) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = pra_pkg::STATUS_BAD_ADDR;
                  end else begin
                     state_in = pra_pkg::ST_COUNT;
                  end
               end else begin
                  rsp_valid_in = 1'b1;
               end
            end
         end
         pra_pkg::ST_ALLOC: begin
            cmd.pop      = 1'b1;
            rsp_valid_in = 1'b1;
            rsp_addr_in  = alloc_wide << PAGE_SHIFT;
            state_in     = pra_pkg::ST_IDLE;
         end
         pra_pkg::ST_COUNT: begin
            rsp_valid_in = 1'b1;
            state_in     = pra_pkg::ST_IDLE;
            case (kind_ff)
               pra_pkg::KIND_FREE: begin
                  if (cnt_rdata == '0) begin
                     rsp_status_in = pra_pkg::STATUS_LIMIT;
                  end else begin
                     cnt_we    = 1'b1;
                     cnt_wdata = cnt_rdata - 1'b1;
                     // Last reference dropped: push onto the requester's list.
                     if (cnt_rdata == COUNT_W'(1)) begin
                        cmd.push = 1'b1;
                        lnk_we   = 1'b1;
                     end
                  end
               end
               pra_pkg::KIND_ADD: begin
                  if (cnt_rdata == pra_pkg::COUNT_MAX) begin
                     rsp_status_in = pra_pkg::STATUS_LIMIT;
                  end else begin
                     cnt_we    = 1'b1;
                     cnt_wdata = cnt_rdata + 1'b1;
                  end
               end
               pra_pkg::KIND_SET: begin
                  cnt_we    = 1'b1;
                  cnt_wdata = value_ff;
               end
               pra_pkg::KIND_CHECK: begin
                  rsp_match_in = cnt_rdata == value_ff;
               end
               default: begin
               end
            endcase
         end
         default: begin
            state_in = pra_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pra_pkg::ST_CLEAR;
         clear_ff     <= '0;
         cfg_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clear_ff     <= clear_in;
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      cpu_ff        <= cpu_in;
      page_ff       <= page_in;
      value_ff      <= value_in;
      pop_ff        <= pop_in;
      alloc_ff      <= alloc_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_match_ff  <= rsp_match_in;
      rsp_free_ff   <= rsp_free_in;
   end

   assign busy                 = state_ff != pra_pkg::ST_IDLE;
   assign csr_ready            = 1'b1;
   assign rsp_strobe           = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_page_address     = rsp_addr_ff;
   assign rsp_matches_res      = rsp_match_ff;
   assign rsp_free_bytes_pages = rsp_free_ff;

endmodule

// ===== rtl/pra_checker.sv =====
// Port-level assertions for the page allocator, bound to the top level.
module pra_checker #(
   parameter int PAGE_BYTES = 4096
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         start,
   input logic                         busy,
   input logic                         rsp_strobe,
   input logic [1:0]                   rsp_status,
   input logic [pra_pkg::ADDR_W-1:0]   rsp_page_address,
   input logic                         rsp_matches_res
);

   localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);

   // The count memory is swept after reset, so no request or result can follow at once.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> busy && !rsp_strobe)
      else $error("block not busy clearing after reset");

   // A result only follows an accepted request or work in progress.
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy || start))
      else $error("result without a request");

   // An accepted request either answers at once or goes busy, never both.
   a_accept_split: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy != rsp_strobe))
      else $error("accept followed by both or neither of busy and result");

   // Failures carry no page and no match; pages are always page aligned.
   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status != pra_pkg::STATUS_OK |->
         rsp_page_address == '0 && !rsp_matches_res)
      else $error("failed result carries a page or a match");

   a_aligned: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_page_address[PAGE_SHIFT-1:0] == '0)
      else $error("page address not page aligned");

endmodule

bind refcounted_page_allocator_core pra_checker #(.PAGE_BYTES(PAGE_BYTES)) u_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_strobe       (rsp_strobe),
   .rsp_status       (rsp_status),
   .rsp_page_address (rsp_page_address),
   .rsp_matches_res  (rsp_matches_res)
);
